// ===== hdl/assert_macros.svh =====
// Assertion macros used by the verification checker of the Givens rotation unit.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold after the antecedent, delayed by the dly argument.
`define ASSERT_DELAYED(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("delayed assertion failed");

`endif

// ===== hdl/gru_pkg.sv =====
// Types and constants shared by the Givens rotation unit modules.
// Depends on nothing; every module of the unit imports it.
`default_nettype none

package gru_pkg;

  localparam logic GRU_ACT_GENERATE = 1'b0;
  localparam logic GRU_ACT_APPLY    = 1'b1;

  localparam int GRU_T_FRAC   = 30;
  localparam int GRU_T_W      = 31;
  localparam int GRU_SQ_IN_W  = 62;
  localparam int GRU_ROOT_W   = 31;
  localparam int GRU_SQ_REM_W = 33;
  localparam int GRU_LATENCY  = 104;

  localparam logic signed [31:0] GRU_ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [31:0] GRU_NEG_ONE_Q30 = -32'sh4000_0000;
  localparam logic signed [31:0] GRU_MAX_Q16 = 32'sh7fff_ffff;
  localparam logic signed [31:0] GRU_MIN_Q16 = 32'sh8000_0000;
  localparam logic [61:0] GRU_TWO_POW_60 = 62'h1000_0000_0000_0000;

  typedef struct packed {
    logic               action;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
    logic signed [31:0] cosine_in;
    logic signed [31:0] sine_in;
  } gru_in_t;

  typedef struct packed {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic signed [31:0] cosine_out;
    logic signed [31:0] sine_out;
    logic               saturated;
  } gru_out_t;

  // Per-transaction data that travels alongside the arithmetic pipes.
  typedef struct packed {
    logic               action;
    logic signed [31:0] cos_raw;
    logic signed [31:0] sin_raw;
    logic signed [31:0] ap_first;
    logic signed [31:0] ap_second;
    logic               ap_sat;
    logic               x_neg;
    logic               y_neg;
    logic               b_big;
    logic               both_zero;
    logic [31:0]        big;
    logic [GRU_T_W-1:0] tq;
    logic [32:0]        rr;
  } gru_side_t;

endpackage

`default_nettype wire

// ===== hdl/gru_front.sv =====
// Front stages: magnitudes and ordering for generate, full apply arithmetic.
// Depends on gru_pkg; feeds the first divider of the unit.
`default_nettype none

module gru_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire gru_pkg::gru_in_t  in_item,
  output logic                   out_valid,
  output gru_pkg::gru_side_t     out_side,
  output logic [31:0]            out_small
);
  import gru_pkg::*;

  logic               s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  gru_in_t            s1_item_r;
  logic signed [31:0] s1_c_r, s1_s_r, c_nxt, s_nxt;
  logic [31:0]        s1_ma_r, s1_mb_r, ma_nxt, mb_nxt;

  logic signed [63:0] s2_pcx_r, s2_psy_r, s2_pcy_r, s2_psx_r;
  gru_side_t          s2_side_r, s2_side_nxt;
  logic [31:0]        s2_small_r;

  logic signed [64:0] s3_sum0_r, s3_sum1_r;
  gru_side_t          s3_side_r;
  logic [31:0]        s3_small_r;

  gru_side_t          s4_side_r, s4_side_nxt;
  logic [31:0]        s4_small_r;
  logic [34:0]        q0, q1;
  logic               sat0, sat1;

  always_comb begin
    ma_nxt = in_item.first_operand[31] ? (~in_item.first_operand + 32'd1)
                                       : in_item.first_operand;
    mb_nxt = in_item.second_operand[31] ? (~in_item.second_operand + 32'd1)
                                        : in_item.second_operand;
    priority if (in_item.cosine_in > GRU_ONE_Q30) begin
      c_nxt = GRU_ONE_Q30;
    end else if (in_item.cosine_in < GRU_NEG_ONE_Q30) begin
      c_nxt = GRU_NEG_ONE_Q30;
    end else begin
      c_nxt = in_item.cosine_in;
    end
    priority if (in_item.sine_in > GRU_ONE_Q30) begin
      s_nxt = GRU_ONE_Q30;
    end else if (in_item.sine_in < GRU_NEG_ONE_Q30) begin
      s_nxt = GRU_NEG_ONE_Q30;
    end else begin
      s_nxt = in_item.sine_in;
    end
  end

  always_comb begin
    s2_side_nxt           = '0;
    s2_side_nxt.action    = s1_item_r.action;
    s2_side_nxt.cos_raw   = s1_item_r.cosine_in;
    s2_side_nxt.sin_raw   = s1_item_r.sine_in;
    s2_side_nxt.x_neg     = s1_item_r.first_operand[31];
    s2_side_nxt.y_neg     = s1_item_r.second_operand[31];
    s2_side_nxt.b_big     = s1_mb_r > s1_ma_r;
    s2_side_nxt.both_zero = (s1_ma_r == 32'd0) && (s1_mb_r == 32'd0);
    s2_side_nxt.big       = (s1_mb_r > s1_ma_r) ? s1_mb_r : s1_ma_r;
  end

  always_comb begin
    q0   = s3_sum0_r[64:30];
    q1   = s3_sum1_r[64:30];
    sat0 = !((&q0[34:31]) || (~|q0[34:31]));
    sat1 = !((&q1[34:31]) || (~|q1[34:31]));
    s4_side_nxt = s3_side_r;
    s4_side_nxt.ap_first  = sat0 ? (q0[34] ? GRU_MIN_Q16 : GRU_MAX_Q16) : q0[31:0];
    s4_side_nxt.ap_second = sat1 ? (q1[34] ? GRU_MIN_Q16 : GRU_MAX_Q16) : q1[31:0];
    s4_side_nxt.ap_sat    = sat0 || sat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= in_item;
    s1_c_r     <= c_nxt;
    s1_s_r     <= s_nxt;
    s1_ma_r    <= ma_nxt;
    s1_mb_r    <= mb_nxt;
    s2_pcx_r   <= s1_c_r * s1_item_r.first_operand;
    s2_psy_r   <= s1_s_r * s1_item_r.second_operand;
    s2_pcy_r   <= s1_c_r * s1_item_r.second_operand;
    s2_psx_r   <= s1_s_r * s1_item_r.first_operand;
    s2_side_r  <= s2_side_nxt;
    s2_small_r <= (s1_mb_r > s1_ma_r) ? s1_ma_r : s1_mb_r;
    s3_sum0_r  <= s2_pcx_r + s2_psy_r + 65'sd536870912;
    s3_sum1_r  <= s2_pcy_r - s2_psx_r + 65'sd536870912;
    s3_side_r  <= s2_side_r;
    s3_small_r <= s2_small_r;
    s4_side_r  <= s4_side_nxt;
    s4_small_r <= s3_small_r;
  end

  assign out_valid = s4_valid_r;
  assign out_side  = s4_side_r;
  assign out_small = s4_small_r;

endmodule

`default_nettype wire

// ===== hdl/gru_div_pipe.sv =====
// Restoring divider pipeline, one quotient bit per register stage.
// Depends on gru_pkg for the transaction data carried beside the quotient.
`default_nettype none

module gru_div_pipe #(
  parameter int DW = 62,
  parameter int VW = 32,
  parameter int QW = 31
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [DW-1:0]      dividend,
  input  wire logic [VW-1:0]      divisor,
  input  wire gru_pkg::gru_side_t in_side,
  output logic                    out_valid,
  output logic [QW-1:0]           quotient,
  output gru_pkg::gru_side_t      out_side
);
  import gru_pkg::*;

  // The upper dividend bits must be below the divisor for the quotient to fit.
  logic            v_r    [QW];
  logic [VW-1:0]   rem_r  [QW];
  logic [QW-1:0]   quo_r  [QW];
  logic [QW-1:0]   low_r  [QW];
  logic [VW-1:0]   dvs_r  [QW];
  gru_side_t       side_r [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic          v_c;
      logic [VW-1:0] rem_c, dvs_c, rem_nxt;
      logic [QW-1:0] quo_c, low_c;
      gru_side_t     side_c;
      logic [VW:0]   trial, diff;
      logic          take;

      if (k == 0) begin : g_src
        assign v_c    = in_valid;
        assign rem_c  = VW'(dividend[DW-1:QW]);
        assign quo_c  = '0;
        assign low_c  = dividend[QW-1:0];
        assign dvs_c  = divisor;
        assign side_c = in_side;
      end else begin : g_chain
        assign v_c    = v_r[k-1];
        assign rem_c  = rem_r[k-1];
        assign quo_c  = quo_r[k-1];
        assign low_c  = low_r[k-1];
        assign dvs_c  = dvs_r[k-1];
        assign side_c = side_r[k-1];
      end

      assign trial   = {rem_c, low_c[QW-1]};
      assign diff    = trial - {1'b0, dvs_c};
      assign take    = trial >= {1'b0, dvs_c};
      assign rem_nxt = take ? diff[VW-1:0] : trial[VW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else begin
          v_r[k] <= v_c;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= {quo_c[QW-2:0], take};
        low_r[k]  <= {low_c[QW-2:0], 1'b0};
        dvs_r[k]  <= dvs_c;
        side_r[k] <= side_c;
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign quotient  = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

// ===== hdl/gru_sqrt_pipe.sv =====
// Integer square root pipeline, one root bit per register stage.
// Depends on gru_pkg for widths and the transaction data carried beside the root.
`default_nettype none

module gru_sqrt_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [gru_pkg::GRU_SQ_IN_W-1:0] radicand,
  input  wire gru_pkg::gru_side_t        in_side,
  output logic                           out_valid,
  output logic [gru_pkg::GRU_ROOT_W-1:0] root,
  output gru_pkg::gru_side_t             out_side
);
  import gru_pkg::*;

  localparam int NW  = GRU_SQ_IN_W;
  localparam int RTW = GRU_ROOT_W;
  localparam int RMW = GRU_SQ_REM_W;

  logic           v_r    [RTW];
  logic [RMW-1:0] rem_r  [RTW];
  logic [RTW-1:0] root_r [RTW];
  logic [NW-1:0]  low_r  [RTW];
  gru_side_t      side_r [RTW];

  genvar k;
  generate
    for (k = 0; k < RTW; k++) begin : g_stage
      logic           v_c;
      logic [RMW-1:0] rem_c, rem_nxt;
      logic [RTW-1:0] root_c;
      logic [NW-1:0]  low_c;
      gru_side_t      side_c;
      logic [RMW+1:0] cand, test, diff;
      logic           take;

      if (k == 0) begin : g_src
        assign v_c    = in_valid;
        assign rem_c  = '0;
        assign root_c = '0;
        assign low_c  = radicand;
        assign side_c = in_side;
      end else begin : g_chain
        assign v_c    = v_r[k-1];
        assign rem_c  = rem_r[k-1];
        assign root_c = root_r[k-1];
        assign low_c  = low_r[k-1];
        assign side_c = side_r[k-1];
      end

      assign cand    = {rem_c, low_c[NW-1:NW-2]};
      assign test    = (RMW+2)'({root_c, 2'b01});
      assign diff    = cand - test;
      assign take    = cand >= test;
      assign rem_nxt = take ? diff[RMW-1:0] : cand[RMW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else begin
          v_r[k] <= v_c;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_c[RTW-2:0], take};
        low_r[k]  <= {low_c[NW-3:0], 2'b00};
        side_r[k] <= side_c;
      end
    end
  endgenerate

  assign out_valid = v_r[RTW-1];
  assign root      = root_r[RTW-1];
  assign out_side  = side_r[RTW-1];

endmodule

`default_nettype wire

// ===== hdl/givens_rotation_unit.sv =====
// Each accepted transaction produces one result strobe on out_valid.
// Throughput: one transaction per cycle; busy is never asserted.
// A transaction passes through three 31-stage pipes in series: the ratio divider,
// the square root and the reciprocal divider, plus eleven arithmetic stages.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
// Results cannot be held off by the receiver.
`default_nettype none

module givens_rotation_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire gru_pkg::gru_in_t in_item,
  output logic                  out_valid,
  output gru_pkg::gru_out_t     out_item
);
  import gru_pkg::*;

  logic                f_valid, d1_valid, sq_valid, d2_valid;
  gru_side_t           f_side, d1_side, sq_side, d2_side;
  logic [31:0]         f_small;
  logic [GRU_T_W-1:0]  d1_quo, d2_quo;
  logic [GRU_ROOT_W-1:0] sq_root;

  logic                p5_valid_r, p6_valid_r, p7_valid_r, p8_valid_r;
  logic                p9_valid_r, p10_valid_r, out_valid_r;
  gru_side_t           p5_side_r, p6_side_r, p7_side_r, p8_side_r, p9_side_r, p10_side_r;
  gru_side_t           p5_side_nxt, p8_side_nxt;
  logic [61:0]         p5_tt_r, p6_n_r, p9_prod_r, rnd2;
  logic [62:0]         p7_prod_r, rnd1;
  logic [GRU_ROOT_W-1:0] p7_q_r, p8_q_r;
  logic [60:0]         p8_num;
  logic [GRU_T_W-1:0]  p9_maj_r, p10_maj_r, p10_mnr_r, cm, sm;
  logic [31:0]         cm32, sm32;
  gru_out_t            out_item_r, out_nxt;

  assign busy = 1'b0;

  gru_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_item   (in_item),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_small (f_small)
  );

  gru_div_pipe #(.DW(62), .VW(32), .QW(31)) u_div_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .dividend  ({f_small, 30'd0}),
    .divisor   (f_side.big),
    .in_side   (f_side),
    .out_valid (d1_valid),
    .quotient  (d1_quo),
    .out_side  (d1_side)
  );

  always_comb begin
    p5_side_nxt    = d1_side;
    p5_side_nxt.tq = d1_quo;
  end

  gru_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p6_valid_r),
    .radicand  (p6_n_r),
    .in_side   (p6_side_r),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  always_comb begin
    rnd1           = p7_prod_r + 63'd536870912;
    p8_side_nxt    = p7_side_r;
    p8_side_nxt.rr = rnd1[62:30];
    p8_num         = {1'b1, 30'd0, p8_q_r[GRU_ROOT_W-1:1]};
  end

  gru_div_pipe #(.DW(61), .VW(31), .QW(31)) u_div_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p8_valid_r),
    .dividend  (p8_num),
    .divisor   (p8_q_r),
    .in_side   (p8_side_r),
    .out_valid (d2_valid),
    .quotient  (d2_quo),
    .out_side  (d2_side)
  );

  assign rnd2 = p9_prod_r + 62'd536870912;

  always_comb begin
    cm      = p10_side_r.b_big ? p10_mnr_r : p10_maj_r;
    sm      = p10_side_r.b_big ? p10_maj_r : p10_mnr_r;
    cm32    = {1'b0, cm};
    sm32    = {1'b0, sm};
    out_nxt = '0;
    priority if (p10_side_r.action == GRU_ACT_APPLY) begin
      out_nxt.first_result  = p10_side_r.ap_first;
      out_nxt.second_result = p10_side_r.ap_second;
      out_nxt.cosine_out    = p10_side_r.cos_raw;
      out_nxt.sine_out      = p10_side_r.sin_raw;
      out_nxt.saturated     = p10_side_r.ap_sat;
    end else if (p10_side_r.both_zero) begin
      out_nxt.cosine_out = GRU_ONE_Q30;
    end else begin
      out_nxt.cosine_out = p10_side_r.x_neg ? (32'd0 - cm32) : cm32;
      out_nxt.sine_out   = p10_side_r.y_neg ? (32'd0 - sm32) : sm32;
      if (p10_side_r.rr[32:31] != 2'b00) begin
        out_nxt.first_result = GRU_MAX_Q16;
        out_nxt.saturated    = 1'b1;
      end else begin
        out_nxt.first_result = {1'b0, p10_side_r.rr[30:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_valid_r  <= 1'b0;
      p6_valid_r  <= 1'b0;
      p7_valid_r  <= 1'b0;
      p8_valid_r  <= 1'b0;
      p9_valid_r  <= 1'b0;
      p10_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p5_valid_r  <= d1_valid;
      p6_valid_r  <= p5_valid_r;
      p7_valid_r  <= sq_valid;
      p8_valid_r  <= p7_valid_r;
      p9_valid_r  <= d2_valid;
      p10_valid_r <= p9_valid_r;
      out_valid_r <= p10_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p5_side_r  <= p5_side_nxt;
    p5_tt_r    <= d1_quo * d1_quo;
    p6_side_r  <= p5_side_r;
    p6_n_r     <= p5_tt_r + GRU_TWO_POW_60;
    p7_side_r  <= sq_side;
    p7_prod_r  <= sq_side.big * sq_root;
    p7_q_r     <= sq_root;
    p8_side_r  <= p8_side_nxt;
    p8_q_r     <= p7_q_r;
    p9_side_r  <= d2_side;
    p9_prod_r  <= d2_side.tq * d2_quo;
    p9_maj_r   <= d2_quo;
    p10_side_r <= p9_side_r;
    p10_mnr_r  <= rnd2[60:30];
    p10_maj_r  <= p9_maj_r;
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hdl/gru_checker.sv =====
// Port-level checker for the Givens rotation unit and its bind to the top level.
// Depends on gru_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gru_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire gru_pkg::gru_in_t  in_item,
  input wire logic              out_valid,
  input wire gru_pkg::gru_out_t out_item
);
  import gru_pkg::*;

  // Every accepted transaction must be followed by a result strobe.
  `ASSERT_DELAYED(a_result_follows, clk, rst_n, start && !busy, GRU_LATENCY, out_valid)

  `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, GRU_LATENCY))

  `ASSERT_IMPLIES(a_sat_clamped, clk, rst_n, out_valid && out_item.saturated, (out_item.first_result == GRU_MAX_Q16) || (out_item.first_result == GRU_MIN_Q16) || (out_item.second_result == GRU_MAX_Q16) || (out_item.second_result == GRU_MIN_Q16))

  `ASSERT_DELAYED(a_apply_echo, clk, rst_n, start && !busy && (in_item.action == GRU_ACT_APPLY), GRU_LATENCY, (out_item.cosine_out == $past(in_item.cosine_in, GRU_LATENCY)) && (out_item.sine_out == $past(in_item.sine_in, GRU_LATENCY)))

endmodule

bind givens_rotation_unit gru_checker u_gru_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the Givens rotation unit: drives generate and apply transactions,
// predicts each result in fixed point and compares it field by field.
// Depends on gru_pkg and givens_rotation_unit.
`timescale 1ns / 1ps

module tb;
  import gru_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  gru_in_t  in_item = '0;
  logic     out_valid;
  gru_out_t out_item;

  gru_out_t pending_rotations[$];
  int       error_count = 0;
  int       n_generate = 0;
  int       n_apply = 0;
  int       n_saturated = 0;

  typedef struct {
    gru_in_t  stim;
    bit       has_expected;
    gru_out_t expected;
  } row_t;

  givens_rotation_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [63:0] limit_q30(logic signed [63:0] v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic logic signed [31:0] round_q16(logic signed [63:0] sum, ref logic sat);
    logic signed [63:0] q;
    q = (sum + 64'sd536870912) >>> 30;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return GRU_MAX_Q16;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return GRU_MIN_Q16;
    end
    return q[31:0];
  endfunction

  function automatic gru_out_t rotate_predict(gru_in_t t);
    gru_out_t r;
    logic signed [63:0] x, y, c, s;
    logic [63:0] ma, mb, big, sml, tq, q, maj, mnr, rr, cm, sm;
    logic bbig, sat;
    r = '0;
    sat = 1'b0;
    x = t.first_operand;
    y = t.second_operand;
    if (t.action == GRU_ACT_GENERATE) begin
      ma = x < 0 ? -x : x;
      mb = y < 0 ? -y : y;
      if (ma == 0 && mb == 0) begin
        r.cosine_out = GRU_ONE_Q30;
      end else begin
        bbig = mb > ma;
        big = bbig ? mb : ma;
        sml = bbig ? ma : mb;
        tq = (sml << 30) / big;
        q = int_sqrt((64'd1 << 60) + tq * tq);
        maj = ((64'd1 << 60) + (q >> 1)) / q;
        mnr = (tq * maj + (64'd1 << 29)) >> 30;
        rr = (big * q + (64'd1 << 29)) >> 30;
        cm = bbig ? mnr : maj;
        sm = bbig ? maj : mnr;
        r.cosine_out = x < 0 ? -cm[31:0] : cm[31:0];
        r.sine_out = y < 0 ? -sm[31:0] : sm[31:0];
        if (rr > 64'd2147483647) begin
          rr = 64'd2147483647;
          sat = 1'b1;
        end
        r.first_result = rr[31:0];
      end
    end else begin
      c = limit_q30(64'(t.cosine_in));
      s = limit_q30(64'(t.sine_in));
      r.first_result = round_q16(c * x + s * y, sat);
      r.second_result = round_q16(c * y - s * x, sat);
      r.cosine_out = t.cosine_in;
      r.sine_out = t.sine_in;
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic gru_in_t make_item(logic act, int a, int b, int c, int s);
    gru_in_t t;
    t.action = act;
    t.first_operand = a;
    t.second_operand = b;
    t.cosine_in = c;
    t.sine_in = s;
    return t;
  endfunction

  function automatic int rand_operand();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 131072)) - 65536;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom_range(0, 2000000000)) - 1000000000;
    endcase
  endfunction

  function automatic int rand_trig();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
      default: return $signed($urandom_range(0, 32'h80000000)) - 32'sh40000000;
    endcase
  endfunction

  task automatic send_rotation(gru_in_t t);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rotations.push_back(rotate_predict(t));
    if (t.action == GRU_ACT_GENERATE) n_generate++;
    else n_apply++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rotations.size() == 0) begin
        $error("result with no transaction outstanding");
        error_count++;
      end else begin
        gru_out_t e;
        e = pending_rotations.pop_front();
        check_field("first_result", e.first_result, out_item.first_result);
        check_field("second_result", e.second_result, out_item.second_result);
        check_field("cosine_out", e.cosine_out, out_item.cosine_out);
        check_field("sine_out", e.sine_out, out_item.sine_out);
        check_field("saturated", 32'(e.saturated), 32'(out_item.saturated));
        if (out_item.saturated) n_saturated++;
      end
    end
  end

  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    row_t directed[$];
    row_t row;
    int drain;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row.has_expected = 1'b1;
    row.stim = make_item(GRU_ACT_GENERATE, 0, 0, 0, 0);
    row.expected = '{0, 0, GRU_ONE_Q30, 0, 1'b0};
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, 32'sh10000, 0, 0, 0);
    row.expected = '{32'sh10000, 0, GRU_ONE_Q30, 0, 1'b0};
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, 0, -32'sh10000, 0, 0);
    row.expected = '{32'sh10000, 0, 0, GRU_NEG_ONE_Q30, 1'b0};
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, 32'sh80000000, 0, 0, 0);
    row.expected = '{GRU_MAX_Q16, 0, GRU_NEG_ONE_Q30, 0, 1'b1};
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 32'sh10000, 32'sh20000, GRU_ONE_Q30, 0);
    row.expected = '{32'sh10000, 32'sh20000, GRU_ONE_Q30, 0, 1'b0};
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 32'sh7fffffff, 32'sh7fffffff,
                         GRU_ONE_Q30, GRU_ONE_Q30);
    row.expected = '{GRU_MAX_Q16, 0, GRU_ONE_Q30, GRU_ONE_Q30, 1'b1};
    directed.push_back(row);
    row.has_expected = 1'b0;
    row.stim = make_item(GRU_ACT_GENERATE, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, -32'sh30000, 32'sh40000, 0, 0);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, 32'sh80000000, 32'sh80000000, 0, 0);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_GENERATE, 1, -1, 32'hffffffff, 32'hffffffff);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 32'sh80000000, 32'sh80000000,
                         GRU_NEG_ONE_Q30, GRU_NEG_ONE_Q30);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 32'sh12345, -32'sh6789a,
                         32'sh7fffffff, 32'sh80000000);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 32'sh7fffffff, 32'sh80000000,
                         32'sh2d413ccd, 32'sh2d413ccd);
    directed.push_back(row);
    row.stim = make_item(GRU_ACT_APPLY, 1, 1, 32'sh20000000, -32'sh20000000);
    directed.push_back(row);

    foreach (directed[i]) begin
      if (directed[i].has_expected &&
          rotate_predict(directed[i].stim) !== directed[i].expected) begin
        $error("table row %0d disagrees with prediction", i);
        error_count++;
      end
      send_rotation(directed[i].stim);
    end

    for (int n = 0; n < 1050; n++) begin
      if (n == 500) begin
        start <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending_rotations.size() != 0 && drain < 2000) begin
          @(posedge clk);
          drain++;
        end
      end
      if (n % 100 < 30) begin
        for (int k = 0; k < 30 && n < 1050; k++, n++) begin
          start <= 1'b1;
          in_item <= make_item(1'($urandom_range(0, 1)), rand_operand(), rand_operand(),
                               rand_trig(), rand_trig());
          @(posedge clk);
          while (busy) @(posedge clk);
          pending_rotations.push_back(rotate_predict(in_item));
          if (in_item.action == GRU_ACT_GENERATE) n_generate++;
          else n_apply++;
        end
      end else begin
        send_rotation(make_item(1'($urandom_range(0, 1)), rand_operand(), rand_operand(),
                                rand_trig(), rand_trig()));
      end
    end

    start <= 1'b0;
    drain = 0;
    while (pending_rotations.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (GRU_LATENCY + 20) @(posedge clk);
    if (pending_rotations.size() != 0) begin
      $error("%0d results never arrived", pending_rotations.size());
      error_count++;
    end
    $display("Covered %0d generate and %0d apply transactions, %0d saturated results.",
             n_generate, n_apply, n_saturated);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gru_pkg.sv
hdl/gru_front.sv
hdl/gru_div_pipe.sv
hdl/gru_sqrt_pipe.sv
hdl/givens_rotation_unit.sv
hdl/gru_checker.sv
sim/tb.sv
